### hw/rtl/bnc_pkg.sv
// ----------------------------------------------------------------------------
// bnc_pkg
// Shared types, codes and character constants for the bracket nesting checker.
// ----------------------------------------------------------------------------
package bnc_pkg;

   // Bracket characters
   localparam logic [7:0] CH_PAREN_OPEN   = 8'h28;  // (
   localparam logic [7:0] CH_SQUARE_OPEN  = 8'h5B;  // [
   localparam logic [7:0] CH_CURLY_OPEN   = 8'h7B;  // {
   localparam logic [7:0] CH_ANGLE_OPEN   = 8'h3C;  // <
   localparam logic [7:0] CH_PAREN_CLOSE  = 8'h29;  // )
   localparam logic [7:0] CH_SQUARE_CLOSE = 8'h5D;  // ]
   localparam logic [7:0] CH_CURLY_CLOSE  = 8'h7D;  // }
   localparam logic [7:0] CH_ANGLE_CLOSE  = 8'h3E;  // >

   // Bracket kinds
   localparam logic [1:0] KIND_PAREN  = 2'd0;
   localparam logic [1:0] KIND_SQUARE = 2'd1;
   localparam logic [1:0] KIND_CURLY  = 2'd2;
   localparam logic [1:0] KIND_ANGLE  = 2'd3;

   // Result status codes
   localparam logic [2:0] ST_PROGRESS   = 3'd0;
   localparam logic [2:0] ST_ILLEGAL    = 3'd1;
   localparam logic [2:0] ST_INCOMPLETE = 3'd2;
   localparam logic [2:0] ST_BALANCED   = 3'd3;
   localparam logic [2:0] ST_CORRUPT    = 3'd4;
   localparam logic [2:0] ST_OVERFLOW   = 3'd5;

   localparam int SCORE_W    = 64;
   localparam int OPEN_DEPTH_W = 7;
   localparam int RSP_TDATA_W  = 80;

   typedef struct packed {
      logic       hit;
      logic [1:0] kind;
   } bracket_type;

   // One stack level: kind, running score of the bottom levels, 5^level
   typedef struct packed {
      logic [1:0]         kind;
      logic [SCORE_W-1:0] score;
      logic [SCORE_W-1:0] pow;
   } entry_type;

   typedef struct packed {
      logic       push;
      logic       pop;
      logic       clear;
      logic [1:0] kind;
   } stack_cmd_type;

   typedef struct packed {
      logic               empty;
      logic               full;
      logic [1:0]         top_kind;
      logic [SCORE_W-1:0] after_score;  // top score once the push or pop is applied
   } stack_view_type;

   // Result tdata, msb first
   typedef struct packed {
      logic [3:0]              pad;
      logic [OPEN_DEPTH_W-1:0] open_depth;
      logic [SCORE_W-1:0]      completion_score;
      logic [1:0]              bad_kind;
      logic [2:0]              status;
   } rsp_type;

   function automatic bracket_type opener_of(input logic [7:0] ch);
      bracket_type r;
      r = '{hit: 1'b1, kind: KIND_PAREN};
      unique case (ch)
         CH_PAREN_OPEN:  r.kind = KIND_PAREN;
         CH_SQUARE_OPEN: r.kind = KIND_SQUARE;
         CH_CURLY_OPEN:  r.kind = KIND_CURLY;
         CH_ANGLE_OPEN:  r.kind = KIND_ANGLE;
         default:        r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic bracket_type closer_of(input logic [7:0] ch);
      bracket_type r;
      r = '{hit: 1'b1, kind: KIND_PAREN};
      unique case (ch)
         CH_PAREN_CLOSE:  r.kind = KIND_PAREN;
         CH_SQUARE_CLOSE: r.kind = KIND_SQUARE;
         CH_CURLY_CLOSE:  r.kind = KIND_CURLY;
         CH_ANGLE_CLOSE:  r.kind = KIND_ANGLE;
         default:         r.hit  = 1'b0;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/bnc_stack_ram.sv
// ----------------------------------------------------------------------------
// bnc_stack_ram
// Stack body below the top level: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bnc_stack_ram
   import bnc_pkg::*;
#(
   parameter int DEPTH = 63,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bnc_stack.sv
// ----------------------------------------------------------------------------
// bnc_stack
// Bracket stack with a registered top entry and a prefetched entry below it;
// builds the base-5 running score on each push.
// ----------------------------------------------------------------------------
module bnc_stack
   import bnc_pkg::*;
#(
   parameter  int MAX_DEPTH = 64,
   localparam int DW        = $clog2(MAX_DEPTH + 1),
   localparam int AW        = $clog2(MAX_DEPTH)
) (
   input  logic           clock,
   input  logic           reset,
   input  stack_cmd_type  cmd_i,
   output logic [DW-1:0]  depth_o,
   output stack_view_type view_o
);

   logic [DW-1:0]      depth_ff, depth_in;
   logic [SCORE_W-1:0] nxt_pow_ff, nxt_pow_in;   // 5^depth
   entry_type          top_ff, top_in;
   entry_type          byp_ff, byp_in;
   logic               byp_sel_ff, byp_sel_in;

   entry_type          rd_data;
   entry_type          below;
   entry_type          push_entry;
   logic [SCORE_W-1:0] digit_mult;
   logic [SCORE_W-1:0] base_score;
   logic [DW-1:0]      wr_ptr, rd_ptr;
   logic               wr_en, rd_en;

   // digit (kind + 1) times 5^depth
   always_comb begin
      unique case (cmd_i.kind)
         KIND_PAREN:  digit_mult = nxt_pow_ff;
         KIND_SQUARE: digit_mult = nxt_pow_ff << 1;
         KIND_CURLY:  digit_mult = (nxt_pow_ff << 1) + nxt_pow_ff;
         KIND_ANGLE:  digit_mult = nxt_pow_ff << 2;
         default:     digit_mult = nxt_pow_ff;
      endcase
   end

   assign base_score       = (depth_ff == '0) ? '0 : top_ff.score;
   assign push_entry.kind  = cmd_i.kind;
   assign push_entry.pow   = nxt_pow_ff;
   assign push_entry.score = base_score + digit_mult;

   assign below = byp_sel_ff ? byp_ff : rd_data;

   always_comb begin
      depth_in   = depth_ff;
      nxt_pow_in = nxt_pow_ff;
      top_in     = top_ff;
      byp_in     = byp_ff;
      byp_sel_in = byp_sel_ff;
      priority if (cmd_i.clear) begin
         depth_in   = '0;
         nxt_pow_in = SCORE_W'(1);
      end else if (cmd_i.push) begin
         depth_in   = depth_ff + DW'(1);
         nxt_pow_in = (nxt_pow_ff << 2) + nxt_pow_ff;
         top_in     = push_entry;
         byp_in     = top_ff;     // old top becomes the entry below
         byp_sel_in = 1'b1;
      end else if (cmd_i.pop) begin
         depth_in   = depth_ff - DW'(1);
         nxt_pow_in = top_ff.pow;
         top_in     = below;
         byp_sel_in = 1'b0;       // next below comes from the RAM read
      end
   end

   // old top is saved at depth-1; after a pop the new below lives at depth-3
   assign wr_ptr = depth_ff - DW'(1);
   assign rd_ptr = depth_ff - DW'(3);
   assign wr_en  = cmd_i.push && !cmd_i.clear && (depth_ff != '0);
   assign rd_en  = cmd_i.pop && !cmd_i.clear;

   bnc_stack_ram #(
      .DEPTH (MAX_DEPTH - 1),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_ptr[AW-1:0]),
      .wr_data (top_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         nxt_pow_ff <= SCORE_W'(1);
         byp_sel_ff <= 1'b0;
      end else begin
         depth_ff   <= depth_in;
         nxt_pow_ff <= nxt_pow_in;
         byp_sel_ff <= byp_sel_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      byp_ff <= byp_in;
   end

   always_comb begin
      view_o.empty    = (depth_ff == '0);
      view_o.full     = (depth_ff == DW'(MAX_DEPTH));
      view_o.top_kind = top_ff.kind;
      if (cmd_i.push) begin
         view_o.after_score = push_entry.score;
      end else if (cmd_i.pop) begin
         view_o.after_score = below.score;
      end else begin
         view_o.after_score = top_ff.score;
      end
   end

   assign depth_o = depth_ff;

endmodule

### hw/rtl/bracket_nesting_checker.sv
// ----------------------------------------------------------------------------
// bracket_nesting_checker
// Checks nesting of ( [ { < brackets per line and scores unfinished lines.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* is the character stream: one byte per transfer in req_tdata, with
//    req_tlast high on the last byte of a line.
//  - rsp_* returns exactly one result per character: status, the kind of an
//    illegal closer, the base-5 completion score (only for an incomplete
//    line) and the number of brackets still open.
//  - A character is taken into the input register, and its result is then
//    offered from the result register.
//  - Throughput: one character per cycle while the result is not stalled; the
//    push/pop, top compare and score add all sit between the input register
//    and the result register, and the stack RAM below the top entry is read ahead.
//  - When rsp_tready is low the result holds and the input register still
//    takes one more character; after that req_tready drops until the
//    result is taken.
//  - Reset empties the stack and clears the line flags; stack contents are
//    not cleared, only the depth counter.
// ----------------------------------------------------------------------------
module bracket_nesting_checker
   import bnc_pkg::*;
#(
   parameter int MAX_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // character stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [7:0] character
   input  logic                   req_tlast,   // end_of_line
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata    // [2:0] status, [4:3] bad_kind,
                                               // [68:5] completion_score,
                                               // [75:69] open_depth, [79:76] 0
);

   localparam int DW = $clog2(MAX_DEPTH + 1);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eol_ff;

   // line state
   logic       corrupt_ff, corrupt_in;
   logic       overflow_ff, overflow_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic           advance;
   logic           take_req;
   bracket_type    opener, closer;
   logic           ignore_line;
   logic           do_push, do_pop, ovf_set, mismatch;
   logic [DW-1:0]  depth, depth_after;
   stack_cmd_type  cmd;
   stack_view_type view;

   // item moves from input register to result register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take_req   = req_tvalid && req_tready;

   assign opener      = opener_of(in_char_ff);
   assign closer      = closer_of(in_char_ff);
   assign ignore_line = corrupt_ff || overflow_ff;

   assign do_push  = !ignore_line && opener.hit && !view.full;
   assign ovf_set  = !ignore_line && opener.hit && view.full;
   // closer on an empty stack counts as a mismatch
   assign mismatch = !ignore_line && closer.hit &&
                     (view.empty || (view.top_kind != closer.kind));
   assign do_pop   = !ignore_line && closer.hit && !mismatch;

   assign cmd.push  = advance && do_push;
   assign cmd.pop   = advance && do_pop;
   assign cmd.clear = advance && in_eol_ff;
   assign cmd.kind  = opener.kind;

   bnc_stack #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_stack (
      .clock   (clock),
      .reset   (reset),
      .cmd_i   (cmd),
      .depth_o (depth),
      .view_o  (view)
   );

   assign depth_after = depth + DW'(do_push) - DW'(do_pop);

   // result and line-state update
   always_comb begin
      rsp_in.pad              = '0;
      rsp_in.open_depth       = OPEN_DEPTH_W'(depth_after);
      rsp_in.bad_kind         = mismatch ? closer.kind : KIND_PAREN;
      rsp_in.completion_score = '0;
      corrupt_in              = corrupt_ff || mismatch;
      overflow_in             = overflow_ff || ovf_set;

      priority if (ovf_set) begin
         rsp_in.status = ST_OVERFLOW;
      end else if (mismatch) begin
         rsp_in.status = ST_ILLEGAL;
      end else begin
         rsp_in.status = ST_PROGRESS;
      end

      // end of line overrides and resets the line state
      if (in_eol_ff) begin
         priority if (overflow_in) begin
            rsp_in.status = ST_OVERFLOW;
         end else if (corrupt_in) begin
            rsp_in.status = ST_CORRUPT;
         end else if (depth_after == '0) begin
            rsp_in.status = ST_BALANCED;
         end else begin
            rsp_in.status           = ST_INCOMPLETE;
            rsp_in.completion_score = view.after_score;
         end
         corrupt_in  = 1'b0;
         overflow_in = 1'b0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         corrupt_ff   <= 1'b0;
         overflow_ff  <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            corrupt_ff  <= corrupt_in;
            overflow_ff <= overflow_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_char_ff <= req_tdata;
         in_eol_ff  <= req_tlast;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

### hw/rtl/bnc_checker.sv
// ----------------------------------------------------------------------------
// bnc_checker
// Port-level checks for the bracket nesting checker, bound to the top level.
// ----------------------------------------------------------------------------
module bnc_checker
   import bnc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [7:0]             req_tdata,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_tdata;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.status <= ST_OVERFLOW) && (rsp.pad == '0))
      else $error("status code out of range");

   a_score_only_incomplete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status != ST_INCOMPLETE) |-> rsp.completion_score == '0)
      else $error("score on a line that is not incomplete");

   a_bad_kind_only_illegal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status != ST_ILLEGAL) && (rsp.status != ST_CORRUPT)
         |-> rsp.bad_kind == KIND_PAREN)
      else $error("bad kind without an illegal closer");

   a_balanced_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status == ST_BALANCED) |-> rsp.open_depth == '0)
      else $error("balanced line with brackets still open");

endmodule

bind bracket_nesting_checker bnc_checker u_bnc_checker (.*);
